[hw/rtl/packet_ring_byte_allocator_defines.svh]
// assertion macros shared by the ring allocator rtl
// no dependencies; include guard keeps a second include harmless
`ifndef PACKET_RING_BYTE_ALLOCATOR_DEFINES_SVH
`define PACKET_RING_BYTE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PRA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pra_pkg.sv]
// types and constants of the ring byte allocator
// no dependencies; used by the register block, the core and the top level
package pra_pkg;

  // configuration register widths and reset values
  localparam int CapW      = 17;
  localparam int MinW      = 16;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;
  localparam logic [CapW-1:0] CapReset = 17'h10000;
  localparam logic [MinW-1:0] MinReset = 16'd32;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_MIN_ENTRY = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_NEXT    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SMALL = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef struct packed {
    logic [CapW-1:0] capacity;
    logic [MinW-1:0] min_entry;
  } cfg_t;

endpackage

[hw/rtl/pra_cfg_regs.sv]
// apb-style register block: ring capacity and minimum entry size
// depends on pra_pkg; a capacity write also pulses the ring clear
module pra_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pra_pkg::PaddrW-1:0]    paddr,
  input  logic [pra_pkg::PdataW-1:0]    pwdata,
  output logic [pra_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output pra_pkg::cfg_t                 cfg_o,
  output logic                          clear_o
);
  import pra_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];
  assign clear_o = wr_en && (reg_idx == REG_CAPACITY);
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity  <= CapReset;
      cfg_q.min_entry <= MinReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAPACITY:  cfg_q.capacity  <= pwdata[CapW-1:0];
        REG_MIN_ENTRY: cfg_q.min_entry <= pwdata[MinW-1:0];
        default:       cfg_q.capacity  <= cfg_q.capacity;
      endcase
    end
  end

  // read data
  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY:  prdata = PdataW'(cfg_q.capacity);
      REG_MIN_ENTRY: prdata = PdataW'(cfg_q.min_entry);
      default:       prdata = '0;
    endcase
  end

endmodule

[hw/rtl/pra_alloc_core.sv]
// ring state (begin, held bytes, tail padding) and its single-pass update
// depends on pra_pkg; outputs show the state after the presented operation
module pra_alloc_core #(
  parameter int ADDR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pra_pkg::cfg_t          cfg_i,
  input  logic                   clear_i,
  input  logic                   exec_i,
  input  pra_pkg::op_e           opcode_i,
  input  logic [ADDR_BITS:0]     byte_count_i,
  input  logic [ADDR_BITS-1:0]   entry_offset_i,
  output logic [1:0]             status_o,
  output logic [ADDR_BITS-1:0]   result_offset_o,
  output logic [ADDR_BITS-1:0]   head_offset_o,
  output logic [ADDR_BITS:0]     held_bytes_o,
  output logic [ADDR_BITS-1:0]   pad_bytes_o
);
  import pra_pkg::*;

  // working width covers the config fields and sums of three ring values
  localparam int BaseW = (ADDR_BITS > CapW) ? ADDR_BITS : CapW;
  localparam int W     = BaseW + 3;

  logic [ADDR_BITS-1:0] begin_q;
  logic [ADDR_BITS:0]   used_q;
  logic [ADDR_BITS-1:0] pad_q;

  logic [W-1:0] cap_max, cap_raw, cap;
  logic [W-1:0] begin_w, used_w, pad_w, bytes_w, entry_w, min_w;
  logic [W-1:0] uend, uend_wrap, pad_new, used_add, nb, nbp, nxt;
  logic [W-1:0] begin_d, used_d, pad_d, res;
  status_e      st;

  // effective capacity: zero or oversize means the full address space
  assign cap_max = W'(1) << ADDR_BITS;
  assign cap_raw = W'(cfg_i.capacity);
  assign cap     = ((cap_raw == '0) || (cap_raw > cap_max)) ? cap_max : cap_raw;

  assign begin_w = W'(begin_q);
  assign used_w  = W'(used_q);
  assign pad_w   = W'(pad_q);
  assign bytes_w = W'(byte_count_i);
  assign entry_w = W'(entry_offset_i);
  assign min_w   = W'(cfg_i.min_entry);

  // shared sums
  assign uend      = begin_w + used_w + pad_w;
  assign uend_wrap = uend - cap;
  assign pad_new   = cap - uend;
  assign used_add  = used_w + bytes_w;
  assign nb        = begin_w + bytes_w;
  assign nbp       = nb + pad_w;
  assign nxt       = entry_w + bytes_w;

  // operation decode and next state
  always_comb begin
    st      = ST_OK;
    res     = '0;
    begin_d = begin_w;
    used_d  = used_w;
    pad_d   = pad_w;
    case (opcode_i)
      OP_PUSH: begin
        if (bytes_w <= min_w) begin
          st = ST_SMALL;
        end else if (uend < cap) begin
          if (uend + bytes_w > cap) begin
            // skip the tail and start at offset zero
            if (used_add + pad_new > cap) begin
              st = ST_FULL;
            end else begin
              pad_d  = pad_new;
              used_d = used_add;
            end
          end else begin
            used_d = used_add;
            res    = uend;
          end
        end else begin
          // end already wrapped below the begin offset
          if (uend_wrap + bytes_w > begin_w) begin
            st = ST_FULL;
          end else begin
            used_d = used_add;
            res    = uend_wrap;
          end
        end
      end
      OP_RELEASE: begin
        if (bytes_w > used_w) begin
          st = ST_OVER;
        end else begin
          if (nbp >= cap) begin
            begin_d = nbp - cap;
            pad_d   = '0;
          end else begin
            begin_d = nb;
          end
          used_d = used_w - bytes_w;
          if (used_d == '0) begin
            begin_d = '0;
          end
        end
      end
      OP_NEXT: begin
        res = (nxt + pad_w == cap) ? '0 : nxt;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign status_o        = st;
  assign result_offset_o = res[ADDR_BITS-1:0];
  assign head_offset_o   = begin_d[ADDR_BITS-1:0];
  assign held_bytes_o    = used_d[ADDR_BITS:0];
  assign pad_bytes_o     = pad_d[ADDR_BITS-1:0];

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= '0;
      used_q  <= '0;
      pad_q   <= '0;
    end else if (clear_i) begin
      begin_q <= '0;
      used_q  <= '0;
      pad_q   <= '0;
    end else if (exec_i) begin
      begin_q <= head_offset_o;
      used_q  <= held_bytes_o;
      pad_q   <= pad_bytes_o;
    end
  end

endmodule

[hw/rtl/packet_ring_byte_allocator.sv]
// contiguous ring byte allocator: input register, single-pass update, result register
// flow: an accepted word waits in the input register, then its result is loaded into the result register
// throughput: one word per cycle while the result channel is not stalled, set by the single ring state update per cycle
// reset: ring empty (begin 0, held 0, padding 0), capacity 65536, min entry 32
// depends on pra_pkg, pra_cfg_regs, pra_alloc_core and the defines header
`include "packet_ring_byte_allocator_defines.svh"

module packet_ring_byte_allocator #(
  parameter int ADDR_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb-style configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pra_pkg::PaddrW-1:0]   paddr,
  input  logic [pra_pkg::PdataW-1:0]   pwdata,
  output logic [pra_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [ADDR_BITS:0]           byte_count_i,
  input  logic [ADDR_BITS-1:0]         entry_offset_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [ADDR_BITS-1:0]         result_offset_o,
  output logic [ADDR_BITS-1:0]         head_offset_o,
  output logic [ADDR_BITS:0]           held_bytes_o,
  output logic [ADDR_BITS-1:0]         pad_bytes_o
);
  import pra_pkg::*;

  cfg_t                 cfg;
  logic                 ring_clear;
  logic                 advance;

  logic                 in_valid_q;
  logic [1:0]           op_q;
  logic [ADDR_BITS:0]   bytes_q;
  logic [ADDR_BITS-1:0] entry_q;

  logic [1:0]           status_d;
  logic [ADDR_BITS-1:0] result_d, head_d, pad_d;
  logic [ADDR_BITS:0]   held_d;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [ADDR_BITS-1:0] result_q, head_q, pad_q;
  logic [ADDR_BITS:0]   held_q;

  pra_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (ring_clear)
  );

  // held word moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= opcode_i;
      bytes_q <= byte_count_i;
      entry_q <= entry_offset_i;
    end
  end

  pra_alloc_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .clear_i         (ring_clear),
    .exec_i          (advance),
    .opcode_i        (op_e'(op_q)),
    .byte_count_i    (bytes_q),
    .entry_offset_i  (entry_q),
    .status_o        (status_d),
    .result_offset_o (result_d),
    .head_offset_o   (head_d),
    .held_bytes_o    (held_d),
    .pad_bytes_o     (pad_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      result_q <= result_d;
      head_q   <= head_d;
      held_q   <= held_d;
      pad_q    <= pad_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_offset_o = result_q;
  assign head_offset_o   = head_q;
  assign held_bytes_o    = held_q;
  assign pad_bytes_o     = pad_q;

  // checks
  `PRA_ASSERT_NEXT(a_stall_keeps_word, clk_i, rst_ni, in_valid_q && !advance, in_valid_q, "held input word lost while stalled")
  `PRA_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, advance, out_valid_q, "executed word produced no result")
  `PRA_ASSERT_IMPL(a_empty_head_zero, clk_i, rst_ni, out_valid_q && (held_q == '0), head_q == '0, "empty ring with nonzero head")
  `PRA_ASSERT_IMPL(a_fail_no_offset, clk_i, rst_ni, out_valid_q && (status_q != ST_OK), result_q == '0, "failed operation reports an offset")

endmodule
